// ===== design/q_learning_frequency_tuner_core_macros.svh =====
// ----------------------------------------------------------------------------
// q-learning frequency tuner assertion macros
// Shared assertion forms for the checker of the tuner core.
// ----------------------------------------------------------------------------
`ifndef Q_LEARNING_FREQUENCY_TUNER_CORE_MACROS_SVH
`define Q_LEARNING_FREQUENCY_TUNER_CORE_MACROS_SVH

// property checked out of reset
`define QLFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define QLFT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/qlft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlft_pkg
// Types, constants and small move helpers shared by the tuner modules.
// ----------------------------------------------------------------------------
package qlft_pkg;

    // grid geometry
    localparam int MAX_CORE_STEPS   = 16;
    localparam int MAX_UNCORE_STEPS = 32;
    localparam int CW   = 4;
    localparam int UW   = 5;
    localparam int PW   = CW + UW;
    localparam int NPOS = MAX_CORE_STEPS * MAX_UNCORE_STEPS;
    localparam int NMOVES = 9;
    localparam int MW   = 4;
    localparam int QAW  = 13;
    localparam int QDEPTH = NPOS * NMOVES;

    localparam logic [MW-1:0] MV_CENTRE = 4'd4;
    localparam logic [MW-1:0] MV_LAST   = 4'd8;
    localparam logic [PW-1:0] POS_LAST  = 9'(NPOS - 1);

    localparam logic [4:0] CS_MAX = 5'(MAX_CORE_STEPS);
    localparam logic [5:0] US_MAX = 6'(MAX_UNCORE_STEPS);

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 17;
    localparam logic [CFG_IW-1:0] CFG_CORE_STEPS   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_UNCORE_STEPS = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LEARN_RATE   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DISCOUNT     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_EXPLORE_RATE = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_START_CORE   = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_START_UNCORE = 3'd6;

    // rates are Q1.16, one is 65536
    localparam logic [CFG_DW-1:0] RATE_ONE = 17'd65536;

    typedef struct packed {
        logic            clr_wr;
        logic [PW-1:0]   clr_pos;
        logic [MW-1:0]   m;
        logic            load_in;
        logic            pick;
        logic            take_best;
        logic            emit;
        logic            e_wr;
        logic            e_rd;
        logic            e_rd_prev;
        logic            ld_upd;
        logic            upd_prev;
        logic            scan_init;
        logic            scan_nb;
        logic            scan_rd;
        logic            div_start;
        logic            u_rd;
        logic            u_m1;
        logic            u_m2;
        logic            u_m3;
        logic            u_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic                action;
        logic                explore;
        logic [NMOVES-1:0]   cur_valid;
        logic                known;
        logic                div_done;
        logic                out_full;
    } t_dp_stat;

    // core delta plus one of a move
    function automatic logic [1:0] mv_dc(input logic [MW-1:0] m);
        logic [1:0] d;
        unique case (m)
            4'd0, 4'd1, 4'd2: d = 2'd0;
            4'd6, 4'd7, 4'd8: d = 2'd2;
            default:          d = 2'd1;
        endcase
        return d;
    endfunction

    // uncore delta plus one of a move
    function automatic logic [1:0] mv_du(input logic [MW-1:0] m);
        logic [1:0] d;
        unique case (m)
            4'd0, 4'd3, 4'd6: d = 2'd0;
            4'd2, 4'd5, 4'd8: d = 2'd2;
            default:          d = 2'd1;
        endcase
        return d;
    endfunction

    // target inside the grid in use; centre always allowed
    function automatic logic move_ok(input logic [CW-1:0] c, input logic [UW-1:0] u,
                                     input logic [MW-1:0] m, input logic [4:0] cs,
                                     input logic [5:0] us);
        logic [4:0] nc;
        logic [5:0] nu;
        nc = {1'b0, c} + {3'b000, mv_dc(m)};
        nu = {1'b0, u} + {4'b0000, mv_du(m)};
        return (m == MV_CENTRE) ||
               (nc >= 5'd1 && nc <= cs && nu >= 6'd1 && nu <= us);
    endfunction

    // q table address of a position and move
    function automatic logic [QAW-1:0] q_addr(input logic [PW-1:0] pos,
                                              input logic [MW-1:0] m);
        return QAW'({pos, 3'b000}) + QAW'(pos) + QAW'(m);
    endfunction

endpackage

// ===== design/qlft_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlft_req_if
// Request channel of the tuner: choose or report words.
// ----------------------------------------------------------------------------
interface qlft_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] explore_draw;
    logic [15:0] pick_draw;
    logic [31:0] energy;

    modport source (output valid, action, explore_draw, pick_draw, energy, input ready);
    modport sink   (input valid, action, explore_draw, pick_draw, energy, output ready);
endinterface

// ===== design/qlft_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlft_rsp_if
// Result channel of the tuner: new grid indices.
// ----------------------------------------------------------------------------
interface qlft_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] core_index;
    logic [4:0] uncore_index;
    logic       explored;

    modport source (output valid, core_index, uncore_index, explored, input ready);
    modport sink   (input valid, core_index, uncore_index, explored, output ready);
endinterface

// ===== design/q_learning_frequency_tuner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_learning_frequency_tuner_core
// Tabular q-learning over a core/uncore frequency step grid.
// ----------------------------------------------------------------------------
// After reset the block initializes the q table and the energy-known flags
// (one table entry per cycle) and takes no word until then; configuration
// writes are taken at any time. A choose word then picks a random valid move
// when exploring; when greedy it reads the nine q entries of the current
// position one per cycle from the q table port and takes the best of them.
// A report word writes its energy, then makes one check per move plus a
// final one, one energy read per valid neighbour, and, for the last move and
// for each valid neighbour with a known energy, a nine-read max scan with a
// settle step, a start step, a bit-serial reward divide and a q update that
// reads the entry, forms the products and the difference, and writes it back.
// One word is worked at a time; a finished result waits in the output register.
module q_learning_frequency_tuner_core import qlft_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qlft_req_if.sink          i_req,
    qlft_rsp_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    qlft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // tables and arithmetic
    qlft_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_req.action),
        .i_explore_draw (i_req.explore_draw),
        .i_pick_draw    (i_req.pick_draw),
        .i_energy       (i_req.energy),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_core_index   (o_rsp.core_index),
        .o_uncore_index (o_rsp.uncore_index),
        .o_explored     (o_rsp.explored),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

// ===== design/qlft_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlft_dp
// Datapath: tables, position registers, max scan, reward divider, q update.
// ----------------------------------------------------------------------------
module qlft_dp import qlft_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_idx,
    input  logic [CFG_DW-1:0]   i_cfg_wdata,
    input  logic                i_action,
    input  logic [15:0]         i_explore_draw,
    input  logic [15:0]         i_pick_draw,
    input  logic [31:0]         i_energy,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [3:0]          o_core_index,
    output logic [4:0]          o_uncore_index,
    output logic                o_explored,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat
);

    localparam int QW    = FRAC_BITS + 2;
    localparam int RW    = FRAC_BITS + 3;
    localparam int DCW   = $clog2(QW + 1);
    localparam int ONE_Q = 1 << FRAC_BITS;
    localparam logic signed [31:0] Q_FLOOR = 32'(-ONE_Q);
    localparam logic signed [31:0] Q_CINIT = 32'(-((ONE_Q + 5) / 10));

    // memories
    logic [31:0] qmem [QDEPTH];
    logic [31:0] emem [NPOS];
    logic        kmem [NPOS];

    // configuration
    logic [4:0]  r_core_steps;
    logic [5:0]  r_uncore_steps;
    logic [16:0] r_learn, r_disc, r_erate;

    // state and item
    logic [CW-1:0] r_cur_c, r_prev_c, r_sc;
    logic [UW-1:0] r_cur_u, r_prev_u, r_su;
    logic [MW-1:0] r_prev_m, r_mv, r_bm, r_scan_m;
    logic          r_expl, r_scan_pend;
    logic          r_in_action;
    logic [15:0]   r_edraw, r_pdraw;
    logic [31:0]   r_energy;
    logic signed [31:0] r_best, r_qn, r_old;
    logic [31:0]   r_q_rd, r_e_rd;
    logic          r_k_rd;
    logic [31:0]   r_ea, r_eb;
    logic [QAW-1:0] r_upd_addr;

    // divider
    logic [33:0]   r_rem;
    logic [32:0]   r_sum;
    logic [QW-1:0] r_quo;
    logic [DCW-1:0] r_dcnt;
    logic          r_dbusy, r_dneg, r_dzero;

    // update chain
    logic signed [49:0] r_p1;
    logic signed [35:0] r_td;
    logic signed [53:0] r_p2;

    // output register
    logic          r_ovalid, r_oexpl;
    logic [3:0]    r_oc;
    logic [4:0]    r_ou;

    logic [4:0]  cs;
    logic [5:0]  us;
    logic [16:0] alpha, gamma;
    logic [NMOVES-1:0] cur_mask;
    logic [3:0]  cnt;
    logic [19:0] kprod;
    logic [3:0]  k_sel, seen;
    logic        found;
    logic [MW-1:0] pick_m;
    logic [CW-1:0] nb_c;
    logic [UW-1:0] nb_u;
    logic [PW-1:0] pos_cur, pos_prev, e_raddr;
    logic [QAW-1:0] q_raddr, q_waddr;
    logic          q_we;
    logic [31:0]   q_wdata;
    logic          k_we, k_wdata;
    logic [PW-1:0] k_waddr;
    logic [33:0]   trial;
    logic          ge;
    logic signed [RW-1:0] rwd;
    logic signed [49:0] gq;
    logic signed [35:0] td_n;
    logic signed [53:0] inc;
    logic signed [39:0] newv;
    logic signed [31:0] satv;
    logic [31:0]   mag;

    // effective configuration
    always_comb begin
        cs = (r_core_steps == 5'd0) ? 5'd1 : (r_core_steps > CS_MAX) ? CS_MAX : r_core_steps;
        us = (r_uncore_steps == 6'd0) ? 6'd1 :
             (r_uncore_steps > US_MAX) ? US_MAX : r_uncore_steps;
        alpha = (r_learn > RATE_ONE) ? RATE_ONE : r_learn;
        gamma = (r_disc > RATE_ONE) ? RATE_ONE : r_disc;
    end

    assign pos_cur  = {r_cur_c, r_cur_u};
    assign pos_prev = {r_prev_c, r_prev_u};
    assign nb_c     = r_cur_c + {2'b00, mv_dc(i_cmd.m)} - 4'd1;
    assign nb_u     = r_cur_u + {3'b000, mv_du(i_cmd.m)} - 5'd1;

    // valid moves from the current position
    always_comb begin
        for (int i = 0; i < NMOVES; i++) begin
            cur_mask[i] = move_ok(r_cur_c, r_cur_u, MW'(i), cs, us);
        end
    end

    // random pick among valid moves
    always_comb begin
        cnt = '0;
        for (int i = 0; i < NMOVES; i++) begin
            cnt = cnt + {3'b000, cur_mask[i]};
        end
        kprod  = 20'(r_pdraw) * 20'(cnt);
        k_sel  = kprod[19:16];
        seen   = '0;
        found  = 1'b0;
        pick_m = MV_CENTRE;
        for (int i = 0; i < NMOVES; i++) begin
            if (cur_mask[i] && !found) begin
                if (seen == k_sel) begin
                    pick_m = MW'(i);
                    found  = 1'b1;
                end else begin
                    seen = seen + 4'd1;
                end
            end
        end
    end

    // memory ports
    always_comb begin
        q_raddr = i_cmd.u_rd ? r_upd_addr : q_addr({r_sc, r_su}, i_cmd.m);
        q_we    = i_cmd.clr_wr || i_cmd.u_wr;
        q_waddr = i_cmd.clr_wr ? q_addr(i_cmd.clr_pos, i_cmd.m) : r_upd_addr;
        q_wdata = i_cmd.clr_wr ? ((i_cmd.m == MV_CENTRE) ? Q_CINIT : 32'd0) : satv;
        e_raddr = i_cmd.e_rd_prev ? pos_prev : {nb_c, nb_u};
        k_we    = (i_cmd.clr_wr && i_cmd.m == 4'd0) || i_cmd.e_wr;
        k_waddr = i_cmd.clr_wr ? i_cmd.clr_pos : pos_cur;
        k_wdata = i_cmd.e_wr;
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            qmem[q_waddr] <= q_wdata;
        end
        r_q_rd <= qmem[q_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.e_wr) begin
            emem[pos_cur] <= r_energy;
        end
        if (i_cmd.e_rd) begin
            r_e_rd <= emem[e_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (k_we) begin
            kmem[k_waddr] <= k_wdata;
        end
        if (i_cmd.e_rd) begin
            r_k_rd <= kmem[e_raddr];
        end
    end

    // divider step and reward value
    always_comb begin
        trial = (r_dcnt == '0) ? r_rem : {r_rem[32:0], 1'b0};
        ge    = trial >= {1'b0, r_sum};
        mag   = (r_ea >= r_eb) ? (r_ea - r_eb) : (r_eb - r_ea);
        rwd   = r_dzero ? '0 :
                r_dneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    end

    // update arithmetic
    always_comb begin
        gq   = (r_p1 + 50'sd32768) >>> 16;
        td_n = 36'(rwd) + 36'(gq) - 36'(r_old);
        inc  = (r_p2 + 54'sd32768) >>> 16;
        newv = 40'(inc) + 40'(r_old);
        if (newv > 40'sd2147483647) begin
            satv = 32'sh7FFFFFFF;
        end else if (newv < -40'sd2147483648) begin
            satv = 32'sh80000000;
        end else begin
            satv = 32'(newv);
        end
    end

    // control registers: configuration, positions, output, divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_steps   <= 5'd15;
            r_uncore_steps <= 6'd20;
            r_learn        <= 17'd6554;
            r_disc         <= 17'd32768;
            r_erate        <= 17'd16384;
            r_cur_c        <= 4'd7;
            r_prev_c       <= 4'd7;
            r_cur_u        <= 5'd9;
            r_prev_u       <= 5'd9;
            r_prev_m       <= MV_CENTRE;
            r_ovalid       <= 1'b0;
            r_dbusy        <= 1'b0;
            r_scan_pend    <= 1'b0;
        end else begin
            r_scan_pend <= i_cmd.scan_rd;
            // output word
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            // move taken
            if (i_cmd.emit) begin
                r_prev_c <= r_cur_c;
                r_prev_u <= r_cur_u;
                r_prev_m <= r_mv;
                r_cur_c  <= r_cur_c + {2'b00, mv_dc(r_mv)} - 4'd1;
                r_cur_u  <= r_cur_u + {3'b000, mv_du(r_mv)} - 5'd1;
            end
            // divider sequencing
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == DCW'(QW - 1)) begin
                r_dbusy <= 1'b0;
            end
            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CORE_STEPS:   r_core_steps   <= i_cfg_wdata[4:0];
                    CFG_UNCORE_STEPS: r_uncore_steps <= i_cfg_wdata[5:0];
                    CFG_LEARN_RATE:   r_learn        <= i_cfg_wdata;
                    CFG_DISCOUNT:     r_disc         <= i_cfg_wdata;
                    CFG_EXPLORE_RATE: r_erate        <= i_cfg_wdata;
                    CFG_START_CORE: begin
                        r_cur_c   <= i_cfg_wdata[3:0];
                        r_prev_c  <= i_cfg_wdata[3:0];
                    end
                    CFG_START_UNCORE: begin
                        r_cur_u   <= i_cfg_wdata[4:0];
                        r_prev_u  <= i_cfg_wdata[4:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_action <= i_action;
            r_edraw     <= i_explore_draw;
            r_pdraw     <= i_pick_draw;
            r_energy    <= i_energy;
        end
        if (i_cmd.pick) begin
            r_mv   <= pick_m;
            r_expl <= 1'b1;
        end
        if (i_cmd.take_best) begin
            r_mv   <= r_bm;
            r_expl <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_oc    <= r_cur_c + {2'b00, mv_dc(r_mv)} - 4'd1;
            r_ou    <= r_cur_u + {3'b000, mv_du(r_mv)} - 5'd1;
            r_oexpl <= r_expl;
        end
        // max scan
        if (i_cmd.scan_init) begin
            r_best <= Q_FLOOR;
            r_bm   <= MV_CENTRE;
            r_sc   <= i_cmd.scan_nb ? nb_c : r_cur_c;
            r_su   <= i_cmd.scan_nb ? nb_u : r_cur_u;
        end else if (r_scan_pend && move_ok(r_sc, r_su, r_scan_m, cs, us) &&
                     $signed(r_q_rd) > r_best) begin
            r_best <= $signed(r_q_rd);
            r_bm   <= r_scan_m;
        end
        r_scan_m <= i_cmd.m;
        // update operands
        if (i_cmd.ld_upd) begin
            if (i_cmd.upd_prev) begin
                r_ea       <= r_e_rd;
                r_eb       <= r_energy;
                r_upd_addr <= q_addr(pos_prev, r_prev_m);
            end else begin
                r_ea       <= r_energy;
                r_eb       <= r_e_rd;
                r_upd_addr <= q_addr(pos_cur, i_cmd.m);
            end
        end
        // reward divider
        if (i_cmd.div_start) begin
            r_qn    <= r_best;
            r_sum   <= {1'b0, r_ea} + {1'b0, r_eb};
            r_dzero <= (r_ea == 32'd0) && (r_eb == 32'd0);
            r_dneg  <= r_ea < r_eb;
            r_rem   <= {2'b00, mag};
            r_quo   <= '0;
            r_dcnt  <= '0;
        end else if (r_dbusy) begin
            r_rem  <= ge ? (trial - {1'b0, r_sum}) : trial;
            r_quo  <= {r_quo[QW-2:0], ge};
            r_dcnt <= r_dcnt + DCW'(1);
        end
        // q update chain
        if (i_cmd.u_m1) begin
            r_old <= $signed(r_q_rd);
            r_p1  <= $signed({1'b0, gamma}) * r_qn;
        end
        if (i_cmd.u_m2) begin
            r_td <= td_n;
        end
        if (i_cmd.u_m3) begin
            r_p2 <= $signed({1'b0, alpha}) * r_td;
        end
    end

    always_comb begin
        o_stat.action    = r_in_action;
        o_stat.explore   = {1'b0, r_edraw} < r_erate;
        o_stat.cur_valid = cur_mask;
        o_stat.known     = r_k_rd;
        o_stat.div_done  = !r_dbusy;
        o_stat.out_full  = r_ovalid && !i_out_ready;
    end

    assign o_out_valid    = r_ovalid;
    assign o_core_index   = r_oc;
    assign o_uncore_index = r_ou;
    assign o_explored     = r_oexpl;

endmodule

// ===== design/qlft_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlft_ctrl
// Sequencer: clearing pass, choose and report flows, neighbour sweep.
// ----------------------------------------------------------------------------
module qlft_ctrl import qlft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DEC   = 5'd2;
    localparam logic [4:0] S_SCAN  = 5'd3;
    localparam logic [4:0] S_SWAIT = 5'd4;
    localparam logic [4:0] S_CTAKE = 5'd5;
    localparam logic [4:0] S_EMIT  = 5'd6;
    localparam logic [4:0] S_RWR   = 5'd7;
    localparam logic [4:0] S_RRD   = 5'd8;
    localparam logic [4:0] S_RCHK  = 5'd9;
    localparam logic [4:0] S_QN    = 5'd10;
    localparam logic [4:0] S_DIV   = 5'd11;
    localparam logic [4:0] S_URD   = 5'd12;
    localparam logic [4:0] S_UM1   = 5'd13;
    localparam logic [4:0] S_UM2   = 5'd14;
    localparam logic [4:0] S_UM3   = 5'd15;
    localparam logic [4:0] S_UWR   = 5'd16;
    localparam logic [4:0] S_NCHK  = 5'd17;
    localparam logic [4:0] S_NRD   = 5'd18;

    localparam logic [1:0] CTX_CHOOSE = 2'd0;
    localparam logic [1:0] CTX_PREV   = 2'd1;
    localparam logic [1:0] CTX_NB     = 2'd2;

    logic [4:0]    r_state, n_state;
    logic [MW-1:0] r_m, n_m, r_j, n_j;
    logic [PW-1:0] r_cp, n_cp;
    logic [1:0]    r_ctx, n_ctx;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_j     = r_j;
        n_cp    = r_cp;
        n_ctx   = r_ctx;
        o_cmd   = '0;
        o_cmd.m = r_m;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.clr_pos = r_cp;
                if (r_m == MV_LAST) begin
                    n_m  = '0;
                    n_cp = r_cp + 9'd1;
                    if (r_cp == POS_LAST) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_m = r_m + 4'd1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.action) begin
                    n_state = S_RWR;
                end else if (i_stat.explore) begin
                    o_cmd.pick = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_ctx   = CTX_CHOOSE;
                    n_j     = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                o_cmd.m = r_j;
                if (r_j == MV_LAST) begin
                    n_state = S_SWAIT;
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            S_SWAIT: n_state = (r_ctx == CTX_CHOOSE) ? S_CTAKE : S_QN;
            S_CTAKE: begin
                o_cmd.take_best = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RWR: begin
                o_cmd.e_wr = 1'b1;
                n_state = S_RRD;
            end
            S_RRD: begin
                o_cmd.e_rd      = 1'b1;
                o_cmd.e_rd_prev = 1'b1;
                n_state = S_RCHK;
            end
            S_RCHK: begin
                if (i_stat.known) begin
                    o_cmd.ld_upd    = 1'b1;
                    o_cmd.upd_prev  = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_ctx   = CTX_PREV;
                    n_j     = '0;
                    n_state = S_SCAN;
                end else begin
                    n_m     = '0;
                    n_state = S_NCHK;
                end
            end
            S_QN: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_URD;
                end
            end
            S_URD: begin
                o_cmd.u_rd = 1'b1;
                n_state = S_UM1;
            end
            S_UM1: begin
                o_cmd.u_m1 = 1'b1;
                n_state = S_UM2;
            end
            S_UM2: begin
                o_cmd.u_m2 = 1'b1;
                n_state = S_UM3;
            end
            S_UM3: begin
                o_cmd.u_m3 = 1'b1;
                n_state = S_UWR;
            end
            S_UWR: begin
                o_cmd.u_wr = 1'b1;
                n_m = (r_ctx == CTX_PREV) ? '0 : r_m + 4'd1;
                n_state = S_NCHK;
            end
            // neighbour sweep in row order
            S_NCHK: begin
                if (r_m > MV_LAST) begin
                    n_state = S_IDLE;
                end else if (i_stat.cur_valid[r_m]) begin
                    o_cmd.e_rd = 1'b1;
                    n_state = S_NRD;
                end else begin
                    n_m = r_m + 4'd1;
                end
            end
            S_NRD: begin
                if (i_stat.known) begin
                    o_cmd.ld_upd    = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    o_cmd.scan_nb   = 1'b1;
                    n_ctx   = CTX_NB;
                    n_j     = '0;
                    n_state = S_SCAN;
                end else begin
                    n_m     = r_m + 4'd1;
                    n_state = S_NCHK;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_m     <= '0;
            r_j     <= '0;
            r_cp    <= '0;
            r_ctx   <= CTX_CHOOSE;
        end else begin
            r_state <= n_state;
            r_m     <= n_m;
            r_j     <= n_j;
            r_cp    <= n_cp;
            r_ctx   <= n_ctx;
        end
    end

endmodule

// ===== design/qlft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlft_checker
// Port-level checks of the tuner core, bound to the top level.
// ----------------------------------------------------------------------------
`include "q_learning_frequency_tuner_core_macros.svh"

module qlft_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_action,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_core_index,
    input logic [4:0] i_uncore_index
);

    // init pass follows every reset
    `QLFT_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> !i_in_ready, "ready during init pass")

    // one word at a time
    `QLFT_ASSERT(a_busy_after_accept, i_in_valid && i_in_ready |=> !i_in_ready, "ready after accept")

    // report words produce no result
    `QLFT_ASSERT(a_report_silent, i_in_valid && i_in_ready && i_in_action |=> !$rose(i_out_valid), "result from report")

    // stalled result word holds
    `QLFT_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")

    `QLFT_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_core_index) && $stable(i_uncore_index), "result changed")

endmodule

bind q_learning_frequency_tuner_core qlft_checker u_qlft_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_in_action    (i_req.action),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_core_index   (o_rsp.core_index),
    .i_uncore_index (o_rsp.uncore_index)
);

// ===== tb/q_learning_frequency_tuner_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_learning_frequency_tuner_core_tb
// Drives choose and report words into the tuner core with random idling on
// both channels. A bit-exact model of the q table, the energy store and the
// grid position predicts each chosen setting, which is checked field by
// field against the result channel.
// ----------------------------------------------------------------------------
module q_learning_frequency_tuner_core_tb import qlft_pkg::*; ();

    localparam bit ACT_CHOOSE = 1'b0;
    localparam bit ACT_REPORT = 1'b1;
    localparam int MV_MID = 4;
    localparam int DRAIN_CYCLES = 400;
    localparam logic [CFG_IW-1:0] CFG_NO_REG = 3'd7;

    typedef struct packed {
        logic [3:0] core;
        logic [4:0] uncore;
        logic       explored;
    } t_grid_step;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_wdata;

    qlft_req_if req();
    qlft_rsp_if rsp();

    q_learning_frequency_tuner_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    logic signed [31:0] q_tab [0:QDEPTH-1];
    logic [31:0]        e_tab [0:NPOS-1];
    bit                 e_known [0:NPOS-1];
    int                 cur_c, cur_u, prev_c, prev_u, prev_mv;
    logic [4:0]         r_cs;
    logic [5:0]         r_us;
    logic [16:0]        r_alpha, r_gamma, r_eps;

    t_grid_step step_q[$];
    int  err_count;
    int  n_choose, n_report, n_checked;
    bit  no_idle;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // limit on the whole run
    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic int slot_of(input int c, input int u);
        return (c % MAX_CORE_STEPS) * MAX_UNCORE_STEPS + (u % MAX_UNCORE_STEPS);
    endfunction

    function automatic bit step_legal(input int c, input int u, input int m);
        int cs, us, nc, nu;
        cs = (r_cs < 1) ? 1 : (r_cs > MAX_CORE_STEPS) ? MAX_CORE_STEPS : int'(r_cs);
        us = (r_us < 1) ? 1 : (r_us > MAX_UNCORE_STEPS) ? MAX_UNCORE_STEPS : int'(r_us);
        nc = c + m / 3;
        nu = u + m % 3;
        if (m == MV_MID) return 1'b1;
        return nc >= 1 && nc <= cs && nu >= 1 && nu <= us;
    endfunction

    // best valid q with a floor of -1.0, first in row order on ties
    function automatic longint peak_q(input int c, input int u, output int mv);
        longint best;
        int p;
        best = -(longint'(1) << 16);
        mv = MV_MID;
        p = slot_of(c, u);
        for (int m = 0; m < NMOVES; m++) begin
            if (step_legal(c, u, m) && longint'(q_tab[p * NMOVES + m]) > best) begin
                best = q_tab[p * NMOVES + m];
                mv = m;
            end
        end
        return best;
    endfunction

    // round(a*b/2^16), ties up
    function automatic longint scale_q16(input longint a, input longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic longint energy_reward(input logic [31:0] eo, input logic [31:0] en);
        longint unsigned sum, mag, quo;
        sum = longint'(eo) + longint'(en);
        if (sum == 0) return 0;
        mag = (eo >= en) ? longint'(eo - en) : longint'(en - eo);
        quo = (mag << 17) / sum;
        return (eo >= en) ? longint'(quo) : -longint'(quo);
    endfunction

    task automatic q_refresh(input int p, input int m, input longint r, input longint qn);
        longint a, g, old, td, nv;
        a = (r_alpha > RATE_ONE) ? 65536 : longint'(r_alpha);
        g = (r_gamma > RATE_ONE) ? 65536 : longint'(r_gamma);
        old = q_tab[p * NMOVES + m];
        td = r + scale_q16(g, qn) - old;
        nv = old + scale_q16(a, td);
        if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        if (nv < -64'sd2147483648) nv = -64'sd2147483648;
        q_tab[p * NMOVES + m] = nv[31:0];
    endtask

    task automatic model_reset();
        r_cs = 5'd15;
        r_us = 6'd20;
        r_alpha = 17'd6554;
        r_gamma = 17'd32768;
        r_eps = 17'd16384;
        for (int i = 0; i < QDEPTH; i++) q_tab[i] = (i % NMOVES == MV_MID) ? -32'sd6554 : 0;
        for (int i = 0; i < NPOS; i++) begin
            e_tab[i] = '0;
            e_known[i] = 1'b0;
        end
        cur_c = 7;
        prev_c = 7;
        cur_u = 9;
        prev_u = 9;
        prev_mv = MV_MID;
    endtask

    task automatic predict_choose(input logic [15:0] ed, input logic [15:0] pd);
        int cnt, k, seen, mv;
        bit expl;
        t_grid_step s;
        cnt = 0;
        seen = 0;
        mv = MV_MID;
        expl = ({1'b0, ed} < r_eps);
        if (expl) begin
            for (int m = 0; m < NMOVES; m++) if (step_legal(cur_c, cur_u, m)) cnt++;
            k = (int'(pd) * cnt) >>> 16;
            for (int m = 0; m < NMOVES; m++) begin
                if (step_legal(cur_c, cur_u, m)) begin
                    if (seen == k) begin
                        mv = m;
                        break;
                    end
                    seen++;
                end
            end
        end else begin
            void'(peak_q(cur_c, cur_u, mv));
        end
        prev_c = cur_c;
        prev_u = cur_u;
        prev_mv = mv;
        cur_c = (cur_c + mv / 3 - 1) & 15;
        cur_u = (cur_u + mv % 3 - 1) & 31;
        s.core = cur_c[3:0];
        s.uncore = cur_u[4:0];
        s.explored = expl;
        step_q.insert(step_q.size(), s);
    endtask

    task automatic predict_report(input logic [31:0] en);
        int pc, pp, pt, tc, tu, dummy;
        longint qn, r;
        pc = slot_of(cur_c, cur_u);
        pp = slot_of(prev_c, prev_u);
        e_tab[pc] = en;
        e_known[pc] = 1'b1;
        // last position and move
        if (e_known[pp]) begin
            qn = peak_q(cur_c, cur_u, dummy);
            r = energy_reward(e_tab[pp], e_tab[pc]);
            q_refresh(pp, prev_mv, r, qn);
        end
        // neighbour sweep in row order
        for (int m = 0; m < NMOVES; m++) begin
            if (!step_legal(cur_c, cur_u, m)) continue;
            tc = cur_c + m / 3 - 1;
            tu = cur_u + m % 3 - 1;
            pt = slot_of(tc, tu);
            if (!e_known[pt]) continue;
            q_refresh(pc, m, energy_reward(e_tab[pc], e_tab[pt]), peak_q(tc, tu, dummy));
        end
    endtask

    // register write, model follows
    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_CORE_STEPS:   r_cs = val[4:0];
            CFG_UNCORE_STEPS: r_us = val[5:0];
            CFG_LEARN_RATE:   r_alpha = val;
            CFG_DISCOUNT:     r_gamma = val;
            CFG_EXPLORE_RATE: r_eps = val;
            CFG_START_CORE: begin
                cur_c = val[3:0];
                prev_c = val[3:0];
            end
            CFG_START_UNCORE: begin
                cur_u = val[4:0];
                prev_u = val[4:0];
            end
            default: ;
        endcase
    endtask

    task automatic set_grid(input int cs, input int us, input int sc, input int su);
        cfg_write(CFG_CORE_STEPS, CFG_DW'(cs));
        cfg_write(CFG_UNCORE_STEPS, CFG_DW'(us));
        cfg_write(CFG_START_CORE, CFG_DW'(sc));
        cfg_write(CFG_START_UNCORE, CFG_DW'(su));
    endtask

    // send one word; called at a falling edge
    task automatic send_word(input bit act, input logic [15:0] ed, input logic [15:0] pd,
                             input logic [31:0] en);
        while (!no_idle && $urandom_range(0, 99) < 12) begin
            req.valid = 1'b0;
            @(negedge i_clk);
        end
        req.valid = 1'b1;
        req.action = act;
        req.explore_draw = ed;
        req.pick_draw = pd;
        req.energy = en;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        if (act == ACT_CHOOSE) begin
            predict_choose(ed, pd);
            n_choose++;
        end else begin
            predict_report(en);
            n_report++;
        end
        @(negedge i_clk);
    endtask

    // block idle: all results back, then the longest report time
    task automatic settle();
        req.valid = 1'b0;
        while (step_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_energy();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 15);
            3, 4:    return $urandom_range(1000, 1100);
            default: return $urandom;
        endcase
    endfunction

    // result check
    always @(posedge i_clk) begin
        t_grid_step want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (step_q.size() == 0) begin
                log_mismatch("result word with nothing expected");
            end else begin
                want = step_q.pop_front();
                n_checked++;
                if (rsp.core_index !== want.core)
                    log_mismatch($sformatf("core_index %0d, expected %0d",
                                           rsp.core_index, want.core));
                if (rsp.uncore_index !== want.uncore)
                    log_mismatch($sformatf("uncore_index %0d, expected %0d",
                                           rsp.uncore_index, want.uncore));
                if (rsp.explored !== want.explored)
                    log_mismatch($sformatf("explored %0b, expected %0b",
                                           rsp.explored, want.explored));
            end
        end
    end

    // result side stalls
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp.ready = no_idle || ($urandom_range(0, 99) >= 12);
        end
    end

    // reset values, greedy and explore picks at both draw ends
    task automatic test_defaults();
        send_word(ACT_CHOOSE, 16'hFFFF, 16'h0000, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'd1000);
        send_word(ACT_CHOOSE, 16'h0000, 16'hFFFF, 32'd0);
        send_word(ACT_REPORT, 16'hFFFF, 16'hFFFF, 32'd0);
        send_word(ACT_CHOOSE, 16'h3FFF, 16'h0000, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    endtask

    // one-step grid, full grid corner, start outside the grid
    task automatic test_grid_edges();
        settle();
        set_grid(0, 0, 0, 0);
        send_word(ACT_CHOOSE, 16'h0000, 16'hFFFF, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'd0);
        send_word(ACT_CHOOSE, 16'hFFFF, 16'h0000, 32'd0);
        settle();
        set_grid(31, 63, 15, 31);
        send_word(ACT_CHOOSE, 16'h0000, 16'hFFFF, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_word(ACT_CHOOSE, 16'hFFFF, 16'h0000, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'd1);
        settle();
        set_grid(2, 2, 15, 31);
        send_word(ACT_CHOOSE, 16'h0000, 16'h0000, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'd7);
        send_word(ACT_CHOOSE, 16'hFFFF, 16'h0000, 32'd0);
    endtask

    // learn, discount and explore rates at their ends, unknown index
    task automatic test_rate_extremes();
        settle();
        cfg_write(CFG_LEARN_RATE, 17'h1FFFF);
        cfg_write(CFG_DISCOUNT, 17'h1FFFF);
        cfg_write(CFG_EXPLORE_RATE, 17'd0);
        cfg_write(CFG_NO_REG, 17'h1FFFF);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'd50);
        send_word(ACT_CHOOSE, 16'h0000, 16'h0000, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'd10);
        settle();
        cfg_write(CFG_LEARN_RATE, 17'd0);
        cfg_write(CFG_DISCOUNT, 17'd0);
        cfg_write(CFG_EXPLORE_RATE, 17'h1FFFF);
        send_word(ACT_CHOOSE, 16'hFFFF, 16'h8000, 32'd0);
        send_word(ACT_REPORT, 16'h0000, 16'h0000, 32'd90);
        settle();
        cfg_write(CFG_EXPLORE_RATE, RATE_ONE);
        send_word(ACT_CHOOSE, 16'hFFFF, 16'h5555, 32'd0);
    endtask

    // random phases of choose/report pairs, with some noise
    task automatic test_random_walk();
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            no_idle = (ph == 2);
            if (ph == 0) set_grid(16, 32, $urandom_range(0, 15), $urandom_range(0, 31));
            else set_grid($urandom_range(0, 31), $urandom_range(0, 63),
                          $urandom_range(0, 15), $urandom_range(0, 31));
            cfg_write(CFG_LEARN_RATE, ($urandom_range(0, 3) == 0) ? RATE_ONE
                                      : CFG_DW'($urandom_range(0, 131071)));
            cfg_write(CFG_DISCOUNT, ($urandom_range(0, 3) == 0) ? RATE_ONE
                                    : CFG_DW'($urandom_range(0, 131071)));
            cfg_write(CFG_EXPLORE_RATE, CFG_DW'($urandom_range(0, 70000)));
            for (int i = 0; i < 200; i++) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_word(ACT_CHOOSE, 16'($urandom), 16'($urandom), $urandom);
                    send_word(ACT_REPORT, 16'($urandom), 16'($urandom), rand_energy());
                end else begin
                    send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                              rand_energy());
                    send_word(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                              rand_energy());
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        err_count = 0;
        n_choose = 0;
        n_report = 0;
        n_checked = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        req.valid = 1'b0;
        req.action = 1'b0;
        req.explore_draw = '0;
        req.pick_draw = '0;
        req.energy = '0;
        model_reset();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults();
        test_grid_edges();
        test_rate_extremes();
        test_random_walk();
        settle();

        $display("Covered %0d choose and %0d report words, %0d results checked.",
                 n_choose, n_report, n_checked);
        $display("Grid sizes, rate extremes and both idle patterns were exercised.");
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
